// File: design/lmft_pkg.sv
// Shared types and field widths for the LED matrix frame transform.
`default_nettype none

package lmft_pkg;

    localparam int ACTION_W    = 3;
    localparam int ROW_IDX_W   = 3;
    localparam int ROW_BITS_W  = 8;
    localparam int SHIFT_W     = 3;
    localparam int ROW_OUT_W   = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE_ROW = 3'd0,
        ACT_READ_ROW  = 3'd1,
        ACT_COL_SHIFT = 3'd2,
        ACT_ROW_SHIFT = 3'd3,
        ACT_ROT_CW    = 3'd4,
        ACT_ROT_CCW   = 3'd5
    } action_t;

endpackage

`default_nettype wire

// File: design/lmft_core.sv
// Next-frame and result-row logic for one action on the LED frame.
`default_nettype none

module lmft_core
    import lmft_pkg::*;
#(
    parameter int MATRIX_SIZE = 8
)
(
    input  wire logic [MATRIX_SIZE-1:0][MATRIX_SIZE-1:0] frame,
    input  wire logic [ACTION_W-1:0]                     action,
    input  wire logic [ROW_IDX_W-1:0]                    row_index,
    input  wire logic [ROW_BITS_W-1:0]                   row_bits,
    input  wire logic [SHIFT_W-1:0]                      shift_amount,
    output logic      [MATRIX_SIZE-1:0][MATRIX_SIZE-1:0] frame_next,
    output logic      [ROW_OUT_W-1:0]                    row_out
);

    localparam int IW = $clog2(MATRIX_SIZE);

    logic [IW-1:0]                              s_mod;
    logic [IW-1:0]                              src_idx [MATRIX_SIZE];
    logic [IW-1:0]                              idx_sel;
    logic                                       idx_ok;
    logic [MATRIX_SIZE-1:0][MATRIX_SIZE-1:0]    col_sh;
    logic [MATRIX_SIZE-1:0][MATRIX_SIZE-1:0]    row_sh;
    logic [MATRIX_SIZE-1:0][MATRIX_SIZE-1:0]    rot_cw;
    logic [MATRIX_SIZE-1:0][MATRIX_SIZE-1:0]    rot_ccw;
    logic [MATRIX_SIZE-1:0]                     sel_row;

    // Reduce the 3-bit shift modulo the size; at most three subtractions.
    always_comb
    begin : shift_mod
        logic [6:0] t;
        t = 7'(shift_amount);
        for (int n = 0; n < 3; n++)
        begin
            if (t >= 7'(MATRIX_SIZE))
            begin
                t = t - 7'(MATRIX_SIZE);
            end
        end
        s_mod = IW'(t);
    end

    // Source position for every destination index: (k - s) mod size.
    always_comb
    begin : src_calc
        logic [IW:0] t;
        for (int k = 0; k < MATRIX_SIZE; k++)
        begin
            t = (IW+1)'(k + MATRIX_SIZE) - {1'b0, s_mod};
            if (t >= (IW+1)'(MATRIX_SIZE))
            begin
                t = t - (IW+1)'(MATRIX_SIZE);
            end
            src_idx[k] = t[IW-1:0];
        end
    end

    always_comb
    begin
        for (int a = 0; a < MATRIX_SIZE; a++)
        begin
            row_sh[a] = frame[src_idx[a]];
            for (int b = 0; b < MATRIX_SIZE; b++)
            begin
                col_sh[a][b]  = frame[a][src_idx[b]];
                rot_cw[a][b]  = frame[MATRIX_SIZE-1-b][a];
                rot_ccw[a][b] = frame[b][MATRIX_SIZE-1-a];
            end
        end
    end

    assign idx_ok  = 7'(row_index) < 7'(MATRIX_SIZE);
    assign idx_sel = IW'(row_index);

    always_comb
    begin
        frame_next = frame;
        unique case (action_t'(action))
            ACT_WRITE_ROW:
            begin
                if (idx_ok)
                begin
                    frame_next[idx_sel] = MATRIX_SIZE'(row_bits);
                end
            end
            ACT_READ_ROW:  frame_next = frame;
            ACT_COL_SHIFT: frame_next = col_sh;
            ACT_ROW_SHIFT: frame_next = row_sh;
            ACT_ROT_CW:    frame_next = rot_cw;
            ACT_ROT_CCW:   frame_next = rot_ccw;
            default:       frame_next = frame;
        endcase
    end

    // Addressed row for write and read, row 0 after anything else.
    always_comb
    begin
        if (action == ACT_WRITE_ROW || action == ACT_READ_ROW)
        begin
            sel_row = idx_ok ? frame_next[idx_sel] : '0;
        end
        else
        begin
            sel_row = frame_next[0];
        end
        row_out = ROW_OUT_W'(sel_row);
    end

endmodule

`default_nettype wire

// File: design/led_matrix_frame_transform.sv
// A result is presented in the cycle after its input transaction is accepted.
// Throughput: one action per cycle; the whole frame sits in one register and every
// transform is a single mux level over it, written back in the accepting cycle.
// in_ready drops only while a finished result waits on a stalled output.
// Reset (rst_n low, asynchronous): frame cleared to all zeros, no result pending.
`default_nettype none

module led_matrix_frame_transform
    import lmft_pkg::*;
#(
    parameter int MATRIX_SIZE = 8
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [ACTION_W-1:0]     action,
    input  wire logic [ROW_IDX_W-1:0]    row_index,
    input  wire logic [ROW_BITS_W-1:0]   row_bits,
    input  wire logic [SHIFT_W-1:0]      shift_amount,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic      [ROW_OUT_W-1:0]    row_out,
    output logic      [ACTION_W-1:0]     done_action
);

    logic [MATRIX_SIZE-1:0][MATRIX_SIZE-1:0] frame_reg;
    logic [MATRIX_SIZE-1:0][MATRIX_SIZE-1:0] frame_next;
    logic [ROW_OUT_W-1:0]                    row_out_next;
    logic [ROW_OUT_W-1:0]                    row_out_reg;
    logic [ACTION_W-1:0]                     action_reg;
    logic                                    out_valid_reg;
    logic                                    accept;

    lmft_core #(
        .MATRIX_SIZE (MATRIX_SIZE)
    ) u_core (
        .frame        (frame_reg),
        .action       (action),
        .row_index    (row_index),
        .row_bits     (row_bits),
        .shift_amount (shift_amount),
        .frame_next   (frame_next),
        .row_out      (row_out_next)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                frame_reg     <= frame_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on accept, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_out_reg <= row_out_next;
            action_reg  <= action;
        end
    end

    assign out_valid   = out_valid_reg;
    assign row_out     = row_out_reg;
    assign done_action = action_reg;

endmodule

`default_nettype wire

// File: design/lmft_checker.sv
// Port-level checks for the LED matrix frame transform, bound to the top level.
`default_nettype none

module lmft_checker
    import lmft_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic [ACTION_W-1:0]   action,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic [ROW_OUT_W-1:0]  row_out,
    input  wire logic [ACTION_W-1:0]   done_action
);

    // Every accepted transaction shows up as a result on the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("no result after accepted transaction");

    a_action_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (done_action == $past(action)))
        else $error("done_action does not echo the accepted action");

    // A stalled result blocks the input side; an empty output never does.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input accepted while a result is stalled");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready with no result pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(row_out) && $stable(done_action)))
        else $error("stalled result changed or dropped");

endmodule

bind led_matrix_frame_transform lmft_checker u_lmft_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .row_out     (row_out),
    .done_action (done_action)
);

`default_nettype wire

// File: tb/led_matrix_frame_transform_tb.sv
// Self-checking testbench for the LED matrix frame transform block.
module led_matrix_frame_transform_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lmft_pkg::*;

    localparam int ROWS         = 8;
    localparam int RANDOM_ITEMS = 1050;
    localparam int IDLE_LIMIT   = 2000;

    // Codes the block does not define; they must leave the frame alone.
    localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

    typedef struct {
        logic [ACTION_W-1:0]   op;
        logic [ROW_IDX_W-1:0]  row;
        logic [ROW_BITS_W-1:0] bits;
        logic [SHIFT_W-1:0]    shift;
        int                    gap;
        bit                    drain;
    } frame_cmd_t;

    typedef struct {
        logic [ROW_OUT_W-1:0] row;
        logic [ACTION_W-1:0]  op;
    } frame_reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [ACTION_W-1:0] action = '0;
    logic [ROW_IDX_W-1:0] row_index = '0;
    logic [ROW_BITS_W-1:0] row_bits = '0;
    logic [SHIFT_W-1:0] shift_amount = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [ROW_OUT_W-1:0] row_out;
    logic [ACTION_W-1:0] done_action;

    frame_cmd_t   cmd_queue[$];
    frame_reply_t reply_queue[$];
    frame_cmd_t   live_cmd;
    frame_reply_t want;

    logic [ROW_BITS_W-1:0] shadow_frame [ROWS];

    bit quiet_sender;
    bit quiet_receiver;
    int gap_count;
    int stall_left;
    int mood_left;
    int idle_cycles;
    int n_total;
    int n_sent;
    int n_checked;
    int n_fail;
    int n_drains;
    int op_count [8];

    led_matrix_frame_transform dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .row_index    (row_index),
        .row_bits     (row_bits),
        .shift_amount (shift_amount),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .row_out      (row_out),
        .done_action  (done_action)
    );

    always #5 clk = ~clk;

    // Mostly back-to-back, sometimes a short pause, rarely a long pause.
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Apply one action to the shadow frame and return the row the block reports.
    function automatic frame_reply_t apply_cmd(frame_cmd_t c);
        logic [ROW_BITS_W-1:0] prev [ROWS];
        frame_reply_t rsp;
        int s;
        prev = shadow_frame;
        s = int'(c.shift) % ROWS;
        case (c.op)
            ACT_WRITE_ROW:
                shadow_frame[c.row] = c.bits;
            ACT_COL_SHIFT:
                for (int i = 0; i < ROWS; i++)
                    shadow_frame[i] = (prev[i] << s) | (prev[i] >> (ROWS - s));
            ACT_ROW_SHIFT:
                for (int i = 0; i < ROWS; i++)
                    shadow_frame[i] = prev[(i + ROWS - s) % ROWS];
            ACT_ROT_CW:
                for (int i = 0; i < ROWS; i++)
                    for (int j = 0; j < ROWS; j++)
                        shadow_frame[j][ROWS-1-i] = prev[i][j];
            ACT_ROT_CCW:
                for (int i = 0; i < ROWS; i++)
                    for (int j = 0; j < ROWS; j++)
                        shadow_frame[ROWS-1-j][i] = prev[i][j];
            default: ;
        endcase
        if (c.op == ACT_WRITE_ROW || c.op == ACT_READ_ROW)
            rsp.row = shadow_frame[c.row];
        else
            rsp.row = shadow_frame[0];
        rsp.op = c.op;
        return rsp;
    endfunction

    task automatic add_cmd(input logic [ACTION_W-1:0] op, input logic [ROW_IDX_W-1:0] row,
                           input logic [ROW_BITS_W-1:0] bits, input logic [SHIFT_W-1:0] shift,
                           input bit drain = 1'b0);
        frame_cmd_t c;
        c.op    = op;
        c.row   = row;
        c.bits  = bits;
        c.shift = shift;
        c.gap   = pick_gap(quiet_sender);
        c.drain = drain;
        cmd_queue.push_back(c);
    endtask

    // Driver: predict on each accepted transaction, then present the next one.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_count = 0;
        end
        else begin
            if (in_valid && in_ready) begin
                reply_queue.push_back(apply_cmd(live_cmd));
                op_count[live_cmd.op]++;
                n_sent++;
            end
            if (!in_valid || in_ready) begin
                if (cmd_queue.size() == 0)
                    in_valid <= 1'b0;
                else if (gap_count < cmd_queue[0].gap) begin
                    in_valid <= 1'b0;
                    gap_count++;
                end
                else if (cmd_queue[0].drain && reply_queue.size() != 0)
                    in_valid <= 1'b0;
                else begin
                    live_cmd = cmd_queue.pop_front();
                    if (live_cmd.drain)
                        n_drains++;
                    in_valid     <= 1'b1;
                    action       <= live_cmd.op;
                    row_index    <= live_cmd.row;
                    row_bits     <= live_cmd.bits;
                    shift_amount <= live_cmd.shift;
                    gap_count = 0;
                end
            end
        end
    end

    // Monitor: check each result against the oldest prediction, stall at random.
    always @(posedge clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else begin
            if (out_valid && out_ready) begin
                if (reply_queue.size() == 0) begin
                    $error("result with nothing expected: row_out=%h done_action=%0d",
                           row_out, done_action);
                    n_fail++;
                end
                else begin
                    want = reply_queue.pop_front();
                    if (row_out !== want.row) begin
                        $error("row_out mismatch: expected %h, actual %h", want.row, row_out);
                        n_fail++;
                    end
                    if (done_action !== want.op) begin
                        $error("done_action mismatch: expected %0d, actual %0d",
                               want.op, done_action);
                        n_fail++;
                    end
                    n_checked++;
                end
            end
            // Periodically choose at random between stalling and steady stretches.
            if (mood_left == 0) begin
                quiet_receiver = ($urandom_range(0, 3) == 0);
                mood_left = 200;
            end
            else
                mood_left--;
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else begin
                out_ready <= 1'b1;
                stall_left = pick_gap(quiet_receiver);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        int r;
        logic [ACTION_W-1:0] op;

        // Extremes of the row data, every action, unused codes, untouched rows.
        add_cmd(ACT_WRITE_ROW, 3'd0, 8'hFF, 3'd0);
        add_cmd(ACT_WRITE_ROW, 3'd7, 8'h01, 3'd7);
        add_cmd(ACT_WRITE_ROW, 3'd3, 8'h80, 3'd0);
        add_cmd(ACT_WRITE_ROW, 3'd5, 8'hAA, 3'd0);
        add_cmd(ACT_READ_ROW,  3'd0, 8'h00, 3'd0);
        add_cmd(ACT_READ_ROW,  3'd7, 8'hFF, 3'd7);
        add_cmd(ACT_READ_ROW,  3'd4, 8'h00, 3'd0);
        add_cmd(ACT_COL_SHIFT, 3'd0, 8'h00, 3'd0);
        add_cmd(ACT_COL_SHIFT, 3'd0, 8'h00, 3'd7);
        add_cmd(ACT_COL_SHIFT, 3'd2, 8'h5A, 3'd3);
        add_cmd(ACT_ROW_SHIFT, 3'd0, 8'h00, 3'd0);
        add_cmd(ACT_ROW_SHIFT, 3'd0, 8'h00, 3'd7);
        add_cmd(ACT_ROW_SHIFT, 3'd6, 8'hC3, 3'd1);
        add_cmd(ACT_ROT_CW,    3'd0, 8'h00, 3'd0);
        add_cmd(ACT_ROT_CCW,   3'd7, 8'hFF, 3'd7);
        add_cmd(ACT_ROT_CCW,   3'd0, 8'h00, 3'd0);
        add_cmd(ACT_SPARE_6,   3'd2, 8'hFF, 3'd5);
        add_cmd(ACT_SPARE_7,   3'd7, 8'h00, 3'd7);
        add_cmd(ACT_READ_ROW,  3'd3, 8'h00, 3'd0);
        add_cmd(ACT_WRITE_ROW, 3'd2, 8'h00, 3'd0);
        add_cmd(ACT_WRITE_ROW, 3'd6, 8'h55, 3'd0);
        add_cmd(ACT_ROT_CW,    3'd0, 8'h00, 3'd0, 1'b1);
        add_cmd(ACT_READ_ROW,  3'd6, 8'h00, 3'd0);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 100 == 0)
                quiet_sender = ($urandom_range(0, 2) == 0);
            r = $urandom_range(0, 99);
            if (r < 28)
                op = ACT_WRITE_ROW;
            else if (r < 48)
                op = ACT_READ_ROW;
            else if (r < 60)
                op = ACT_COL_SHIFT;
            else if (r < 72)
                op = ACT_ROW_SHIFT;
            else if (r < 83)
                op = ACT_ROT_CW;
            else if (r < 94)
                op = ACT_ROT_CCW;
            else
                op = $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
            add_cmd(op, ROW_IDX_W'($urandom_range(0, 7)),
                    ROW_BITS_W'($urandom_range(0, 255)),
                    SHIFT_W'($urandom_range(0, 7)),
                    (k % 350 == 349));
        end
        n_total = cmd_queue.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (n_sent < n_total)
            @(posedge clk);
        while (reply_queue.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        $display("Sent %0d transactions, checked %0d results, %0d pauses to drain",
                 n_sent, n_checked, n_drains);
        $display("Actions: write %0d read %0d colshift %0d rowshift %0d",
                 op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("         cw %0d ccw %0d unused %0d",
                 op_count[4], op_count[5], op_count[6] + op_count[7]);
        if (n_fail == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
